// File: rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// Bidirectional permutation table package
// Shared transaction types, command and status codes, and constants.
// ----------------------------------------------------------------------------
package bpt_pkg;

  // Width of an index field in the first or second ordering.
  localparam int IDX_W = 11;

  // Translation result for an out-of-range or unmapped index.
  localparam logic signed [10:0] MAPPED_NONE = -11'sd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_BWD   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_DUP_FIRST  = 2'd2,
    ST_DUP_SECOND = 2'd3
  } status_t;

  // One input transaction.
  typedef struct packed {
    cmd_t               command;
    logic [10:0]        first_index;
    logic [10:0]        second_index;
    logic signed [11:0] query_index;
    logic               batch_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [10:0] mapped_value;
    status_t            status;
    logic               batch_end_out;
  } out_item_t;

  // A load pair that passed all checks and is written into both tables.
  typedef struct packed {
    logic        en;
    logic [10:0] first_index;
    logic [10:0] second_index;
  } load_commit_t;

endpackage

// File: rtl/core/bpt_mem.sv
// ----------------------------------------------------------------------------
// Bidirectional permutation table memory
// Simple dual-port table with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpt_mem #(
  parameter int AW = 10,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered; a same-cycle write returns the old word.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bpt_sweep.sv
// ----------------------------------------------------------------------------
// Bidirectional permutation table clearing sequencer
// Walks every table entry once to drop its valid mark, after reset and after
// each clear command.
// ----------------------------------------------------------------------------
module bpt_sweep #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_req,
  output logic                           active,
  output logic [$clog2(MAX_ENTRIES)-1:0] addr
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

  logic          active_r;
  logic [AW-1:0] cnt_r;

  // Start on reset or on request, stop after the last entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (clr_req) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (cnt_r == LAST_ADDR) begin
        active_r <= 1'b0;
      end
      cnt_r <= cnt_r + AW'(1);
    end
  end

  assign active = active_r;
  assign addr   = cnt_r;

endmodule

// File: rtl/core/bpt_exec.sv
// ----------------------------------------------------------------------------
// Bidirectional permutation table execute stage
// Holds the accepted transaction, checks range and duplicates against the
// table words read for it, forwards the previous load, and registers the
// result.
// ----------------------------------------------------------------------------
module bpt_exec #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  bpt_pkg::in_item_t     in_item,
  input  logic [10:0]           order_size,
  input  logic [((($clog2(MAX_ENTRIES) < 11) ? $clog2(MAX_ENTRIES) : 11)):0] fwd_rd,
  input  logic [((($clog2(MAX_ENTRIES) < 11) ? $clog2(MAX_ENTRIES) : 11)):0] bwd_rd,
  output bpt_pkg::load_commit_t commit,
  output logic                  clr_req,
  output logic                  out_strobe,
  output bpt_pkg::out_item_t    out_item
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int DW = (AW < 11) ? AW : 11;
  localparam int LW = ($clog2(MAX_ENTRIES + 1) > 11) ? $clog2(MAX_ENTRIES + 1) : 11;
  localparam logic [LW-1:0] MAX_LIM = LW'(MAX_ENTRIES);

  logic                  in_vld_r;
  bpt_pkg::in_item_t     in_r;
  bpt_pkg::load_commit_t last_r;
  logic                  out_strobe_r;
  bpt_pkg::out_item_t    out_r;

  logic [LW-1:0]         lim;
  logic                  first_oor;
  logic                  second_oor;
  logic                  query_oor;
  logic                  is_load;
  logic [10:0]           fwd_key;
  logic [10:0]           bwd_key;
  logic                  fwd_hit;
  logic                  bwd_hit;
  logic                  fwd_valid;
  logic                  bwd_valid;
  logic [10:0]           fwd_value;
  logic [10:0]           bwd_value;
  bpt_pkg::out_item_t    res;
  bpt_pkg::load_commit_t commit_nxt;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
  end

  // Active limit is the smaller of the register and the table depth.
  assign lim = (LW'(order_size) > MAX_LIM) ? MAX_LIM : LW'(order_size);

  assign first_oor  = LW'(in_r.first_index) >= lim;
  assign second_oor = LW'(in_r.second_index) >= lim;
  assign query_oor  = in_r.query_index[11] || (LW'(in_r.query_index[10:0]) >= lim);

  // The table words were read at the same keys when the transaction arrived.
  assign is_load = in_r.command == bpt_pkg::CMD_LOAD;
  assign fwd_key = is_load ? in_r.first_index : in_r.query_index[10:0];
  assign bwd_key = is_load ? in_r.second_index : in_r.query_index[10:0];

  // A load written at the edge of the read is not in the read word yet.
  assign fwd_hit   = last_r.en && (last_r.first_index == fwd_key);
  assign bwd_hit   = last_r.en && (last_r.second_index == bwd_key);
  assign fwd_valid = fwd_hit || fwd_rd[DW];
  assign bwd_valid = bwd_hit || bwd_rd[DW];
  assign fwd_value = fwd_hit ? last_r.second_index : 11'(fwd_rd[DW-1:0]);
  assign bwd_value = bwd_hit ? last_r.first_index : 11'(bwd_rd[DW-1:0]);

  // Command decode and result formation.
  always_comb begin
    res                       = '0;
    res.status                = bpt_pkg::ST_OK;
    res.batch_end_out         = in_r.batch_end;
    commit_nxt.en             = 1'b0;
    commit_nxt.first_index    = in_r.first_index;
    commit_nxt.second_index   = in_r.second_index;
    case (in_r.command)
      bpt_pkg::CMD_LOAD: begin
        if (first_oor || second_oor) begin
          res.status = bpt_pkg::ST_RANGE;
        end else if (fwd_valid) begin
          res.status = bpt_pkg::ST_DUP_FIRST;
        end else if (bwd_valid) begin
          res.status = bpt_pkg::ST_DUP_SECOND;
        end else begin
          commit_nxt.en = in_vld_r;
        end
      end
      bpt_pkg::CMD_FWD: begin
        if (query_oor) begin
          res.mapped_value = bpt_pkg::MAPPED_NONE;
          res.status       = bpt_pkg::ST_RANGE;
        end else begin
          res.mapped_value = fwd_valid ? $signed(fwd_value) : bpt_pkg::MAPPED_NONE;
        end
      end
      bpt_pkg::CMD_BWD: begin
        if (query_oor) begin
          res.mapped_value = bpt_pkg::MAPPED_NONE;
          res.status       = bpt_pkg::ST_RANGE;
        end else begin
          res.mapped_value = bwd_valid ? $signed(bwd_value) : bpt_pkg::MAPPED_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Previous load registered for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r.en <= 1'b0;
    end else begin
      last_r.en <= commit_nxt.en;
    end
    last_r.first_index  <= commit_nxt.first_index;
    last_r.second_index <= commit_nxt.second_index;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res;
  end

  assign commit     = commit_nxt;
  assign clr_req    = in_vld_r && (in_r.command == bpt_pkg::CMD_CLEAR);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// File: rtl/core/bidirectional_permutation_table.sv
// ----------------------------------------------------------------------------
// Bidirectional permutation table
// Forward and backward index tables with pair loading, translation and clear.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high and busy is low, one per
// cycle, and its result passes the input and result registers and is driven
// on out_item with out_strobe high for a single cycle; the receiver cannot
// stall, so results must be taken as they come. Each table is one memory
// with a single read and a single write port, which sets the rate of one
// transaction per cycle outside the clearing pass. Valid marks live in the
// memories and are dropped by a clearing pass over all MAX_ENTRIES entries:
// busy stays high through reset and the pass after it, and after a clear
// command is accepted until its pass ends. order_size is written through the
// cfg port, and the user must write it only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bidirectional_permutation_table #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bpt_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output bpt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int DW = (AW < 11) ? AW : 11;

  logic                  accept;
  logic [10:0]           order_size_r;
  logic                  sweep_active;
  logic [AW-1:0]         sweep_addr;
  logic                  clr_req;
  bpt_pkg::load_commit_t commit;
  logic                  is_load_in;
  logic [AW-1:0]         fwd_raddr;
  logic [AW-1:0]         bwd_raddr;
  logic                  fwd_we;
  logic                  bwd_we;
  logic [AW-1:0]         fwd_waddr;
  logic [AW-1:0]         bwd_waddr;
  logic [DW:0]           fwd_wdata;
  logic [DW:0]           bwd_wdata;
  logic [DW:0]           fwd_rd;
  logic [DW:0]           bwd_rd;

  // Transaction handshake.
  assign busy   = !rst_n || sweep_active || clr_req;
  assign accept = start && !busy;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      order_size_r <= cfg_data;
    end
  end

  // Read keys straight from the input port so the words arrive with the item.
  assign is_load_in = in_item.command == bpt_pkg::CMD_LOAD;
  assign fwd_raddr  = is_load_in ? AW'(in_item.first_index) : AW'(in_item.query_index[10:0]);
  assign bwd_raddr  = is_load_in ? AW'(in_item.second_index) : AW'(in_item.query_index[10:0]);

  // Write side: the clearing pass or an accepted load pair.
  assign fwd_we    = sweep_active || commit.en;
  assign bwd_we    = sweep_active || commit.en;
  assign fwd_waddr = sweep_active ? sweep_addr : AW'(commit.first_index);
  assign bwd_waddr = sweep_active ? sweep_addr : AW'(commit.second_index);
  assign fwd_wdata = sweep_active ? '0 : {1'b1, DW'(commit.second_index)};
  assign bwd_wdata = sweep_active ? '0 : {1'b1, DW'(commit.first_index)};

  bpt_mem #(
    .AW (AW),
    .DW (DW + 1)
  ) u_fwd_mem (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (fwd_raddr),
    .rdata (fwd_rd)
  );

  bpt_mem #(
    .AW (AW),
    .DW (DW + 1)
  ) u_bwd_mem (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_waddr),
    .wdata (bwd_wdata),
    .raddr (bwd_raddr),
    .rdata (bwd_rd)
  );

  bpt_sweep #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_req (clr_req),
    .active  (sweep_active),
    .addr    (sweep_addr)
  );

  bpt_exec #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .order_size (order_size_r),
    .fwd_rd     (fwd_rd),
    .bwd_rd     (bwd_rd),
    .commit     (commit),
    .clr_req    (clr_req),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Every accepted transaction gives its result through the input and result registers.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_strobe)
    else $error("result strobe missing two cycles after acceptance");

  // No result is produced without a transaction behind it.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result strobe without an accepted transaction");

  // A load pair is never written while the clearing pass owns the tables.
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(sweep_active && commit.en))
    else $error("load written during clearing pass");

  // A clear command blocks input in the cycle after it is accepted.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.command == bpt_pkg::CMD_CLEAR)) |=> busy)
    else $error("input taken right after a clear command");

endmodule

// File: tb/sv/perm_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Permutation table checker
// Watches the command, result and size channels of the permutation table,
// keeps its own copy of both tables, and compares every result with the
// answer predicted for the oldest outstanding transaction.
// ----------------------------------------------------------------------------
module perm_table_checker #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  bpt_pkg::in_item_t  in_item,
  input  logic               out_strobe,
  input  bpt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  // Shadow copy of both tables, their valid marks and the size register.
  logic [10:0] fwd_partner [MAX_ENTRIES];
  logic [10:0] bwd_partner [MAX_ENTRIES];
  bit          fwd_mapped  [MAX_ENTRIES];
  bit          bwd_mapped  [MAX_ENTRIES];
  logic [10:0] size_reg;

  // Answers predicted for transactions whose results have not come yet.
  bpt_pkg::out_item_t pending_answers [$];
  int                 error_count = 0;

  assign mismatches = error_count;

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // The size in use is capped at the table depth.
  function automatic int active_limit();
    return (int'(size_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_reg);
  endfunction

  // Applies one command to the shadow tables and returns its answer.
  function automatic bpt_pkg::out_item_t apply_command(bpt_pkg::in_item_t it);
    bpt_pkg::out_item_t ans;
    int                 lim;
    int                 f;
    int                 s;
    int                 q;
    ans.mapped_value  = '0;
    ans.status        = bpt_pkg::ST_OK;
    ans.batch_end_out = it.batch_end;
    lim = active_limit();
    f   = int'(it.first_index);
    s   = int'(it.second_index);
    q   = int'(it.query_index[10:0]);
    case (it.command)
      bpt_pkg::CMD_LOAD: begin
        // Any failed check leaves both tables untouched.
        if (f >= lim || s >= lim) begin
          ans.status = bpt_pkg::ST_RANGE;
        end else if (fwd_mapped[f]) begin
          ans.status = bpt_pkg::ST_DUP_FIRST;
        end else if (bwd_mapped[s]) begin
          ans.status = bpt_pkg::ST_DUP_SECOND;
        end else begin
          fwd_partner[f] = it.second_index;
          fwd_mapped[f]  = 1'b1;
          bwd_partner[s] = it.first_index;
          bwd_mapped[s]  = 1'b1;
        end
      end
      bpt_pkg::CMD_FWD, bpt_pkg::CMD_BWD: begin
        // Negative queries have the sign bit set.
        if (it.query_index[11] || q >= lim) begin
          ans.mapped_value = bpt_pkg::MAPPED_NONE;
          ans.status       = bpt_pkg::ST_RANGE;
        end else if (it.command == bpt_pkg::CMD_FWD) begin
          ans.mapped_value = fwd_mapped[q] ? fwd_partner[q] : bpt_pkg::MAPPED_NONE;
        end else begin
          ans.mapped_value = bwd_mapped[q] ? bwd_partner[q] : bpt_pkg::MAPPED_NONE;
        end
      end
      default: begin
        // Clear drops the marks only; entries and size are kept.
        foreach (fwd_mapped[i]) begin
          fwd_mapped[i] = 1'b0;
          bwd_mapped[i] = 1'b0;
        end
      end
    endcase
    return ans;
  endfunction

  // Track every handshake on the three channels.
  always @(posedge clk) begin
    bpt_pkg::out_item_t want;
    if (!rst_n) begin
      size_reg = '0;
      foreach (fwd_mapped[i]) begin
        fwd_mapped[i] = 1'b0;
        bwd_mapped[i] = 1'b0;
      end
      pending_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
      end
      // A result never belongs to the transaction accepted at the same edge, so check before predicting.
      if (out_strobe) begin
        if (pending_answers.size() == 0) begin
          report_error($sformatf("unexpected result: value %0d status %0d end %0d",
                                 out_item.mapped_value, out_item.status,
                                 out_item.batch_end_out));
        end else begin
          want = pending_answers.pop_front();
          if (out_item.mapped_value !== want.mapped_value) begin
            report_error($sformatf("mapped_value %0d, want %0d",
                                   out_item.mapped_value, want.mapped_value));
          end
          if (out_item.status !== want.status) begin
            report_error($sformatf("status %0d, want %0d",
                                   out_item.status, want.status));
          end
          if (out_item.batch_end_out !== want.batch_end_out) begin
            report_error($sformatf("batch_end_out %0d, want %0d",
                                   out_item.batch_end_out, want.batch_end_out));
          end
        end
      end
      if (start && !busy) begin
        pending_answers.push_back(apply_command(in_item));
      end
    end
    outstanding <= pending_answers.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Permutation table testbench
// Drives load, translate and clear commands with random gaps across a range
// of order sizes, and reports the verdict from the checker's error and outstanding counts.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = 1024;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 103;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  bpt_pkg::in_item_t  in_item;
  logic               out_strobe;
  bpt_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [10:0]        cfg_data;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int cur_size     = 0;
  bit burst_mode   = 1'b0;

  // Order sizes visited by the random phases, extremes included.
  int size_plan [12] = '{0, 1, 2047, 1024, 8, 1025, 40, 3, 300, 12, 1023, 64};

  bidirectional_permutation_table #(
    .MAX_ENTRIES(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  perm_table_checker #(
    .MAX_ENTRIES(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int active_limit();
    return (cur_size > DEPTH) ? DEPTH : cur_size;
  endfunction

  function automatic bpt_pkg::in_item_t make_item(bpt_pkg::cmd_t c, int f, int s, int q,
                                                  bit be);
    bpt_pkg::in_item_t it;
    it.command      = c;
    it.first_index  = f[10:0];
    it.second_index = s[10:0];
    it.query_index  = q[11:0];
    it.batch_end    = be;
    return it;
  endfunction

  function automatic int any_index();
    return $urandom_range(0, 2047);
  endfunction

  // Mostly in range and packed into a small window so slots collide often.
  function automatic int pick_index(int lim);
    int r;
    int window;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 12) begin
      return any_index();
    end
    if (r < 17) begin
      return lim;
    end
    window = (lim < 32) ? lim : 32;
    if (r < 70) begin
      return $urandom_range(0, window - 1);
    end
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic bpt_pkg::in_item_t random_item(int lim);
    int            r;
    int            q;
    bpt_pkg::cmd_t c;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      c = bpt_pkg::CMD_CLEAR;
    end else if (r < 45) begin
      c = bpt_pkg::CMD_LOAD;
    end else if (r < 72) begin
      c = bpt_pkg::CMD_FWD;
    end else begin
      c = bpt_pkg::CMD_BWD;
    end
    if (c == bpt_pkg::CMD_LOAD) begin
      return make_item(c, pick_index(lim), pick_index(lim), $urandom_range(0, 4095),
                       1'($urandom_range(0, 1)));
    end
    // A slice of fully random queries covers the negative values.
    q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : pick_index(lim);
    return make_item(c, any_index(), any_index(), q, 1'($urandom_range(0, 1)));
  endfunction

  // Most gaps are short, a few are long.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 50);
  endfunction

  // Holds start high until the block takes the transaction.
  task automatic send_item(bpt_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_size(int v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v[10:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_size = v;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a table of 16 slots.
    write_size(16);
    send_item(make_item(bpt_pkg::CMD_LOAD, 3, 5, -1, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 3, 7, 0, 1'b1));
    send_item(make_item(bpt_pkg::CMD_LOAD, 9, 5, -2048, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 15, 0, 2047, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 16, 1, 5, 1'b1));
    send_item(make_item(bpt_pkg::CMD_LOAD, 2, 16, 5, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 2047, 2047, 5, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 0, 0, 5, 1'b0));
    send_item(make_item(bpt_pkg::CMD_FWD, 0, 2047, 3, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 5, 1'b1));
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 15, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 0, 1'b0));
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 4, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 7, 1'b1));
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 16, 1'b0));
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), -1, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), -2048, 1'b1));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 2047, 1'b0));
    // Shrinking the size hides entries that stay stored.
    write_size(4);
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 15, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 0, 1'b1));
    write_size(16);
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 15, 1'b0));
    // Clear, then reload a pair that was a duplicate before.
    send_item(make_item(bpt_pkg::CMD_CLEAR, any_index(), any_index(), 1, 1'b1));
    send_item(make_item(bpt_pkg::CMD_FWD, any_index(), any_index(), 3, 1'b0));
    send_item(make_item(bpt_pkg::CMD_LOAD, 3, 7, 0, 1'b0));
    send_item(make_item(bpt_pkg::CMD_BWD, any_index(), any_index(), 7, 1'b1));

    // Random phases, each at its own order size; every third one back to back.
    foreach (size_plan[p]) begin
      write_size(size_plan[p]);
      burst_mode = (p % 3 == 2);
      repeat (PHASE_ITEMS) begin
        send_item(random_item(active_limit()));
        if ($urandom_range(0, 99) == 0) begin
          wait_drained();
        end else if (!burst_mode) begin
          idle_gap(random_gap());
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
